@@ rtl/assert_macros.svh @@
// Assertion macros for the checker module of the servo bus packet engine.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is asserted.
`define SBPE_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Assertion that is also checked while the reset is asserted.
`define SBPE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

@@ rtl/sbpe_pkg.sv @@
// Shared types, codes and constants of the servo bus packet engine.
// Depends on nothing; used by every module of the block.
package sbpe_pkg;

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'd254;
  localparam logic [7:0] INS_WRITE    = 8'h03;
  localparam logic [7:0] INS_READ     = 8'h02;
  localparam int unsigned MIN_REPLY_LEN = 6;
  localparam int unsigned LEN_OVERHEAD  = 4;
  localparam int unsigned QUEUE_DEPTH   = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_REPLY = 2'd2,
    OP_EMPTY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RL_NONE  = 2'd0,
    RL_READS = 2'd1,
    RL_ALL   = 2'd2,
    RL_ALL_X = 2'd3
  } ret_level_e;

  typedef enum logic {
    KIND_TX  = 1'b0,
    KIND_CPL = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_BAD_SUM  = 3'd3,
    ST_BAD_LEN  = 3'd4,
    ST_DEV_ERR  = 3'd5,
    ST_WRONG_ID = 3'd6,
    ST_NO_REPLY = 3'd7
  } status_e;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic        is_pkt;    // 1: frame a command packet, 0: report a completion
    logic        is_read;
    logic        wide;      // register is two bytes wide
    logic        need_cpl;  // packet is followed by an immediate completion
    logic [7:0]  id;
    logic [7:0]  addr;
    logic [15:0] val;
    status_e     status;
    logic [7:0]  err;
    logic [15:0] rval;
  } job_t;

  // Registers that hold two-byte values on the device.
  function automatic logic is_wide(input logic [7:0] addr);
    logic w;
    w = 1'b0;
    case (addr) inside
      8'd0, 8'd6, 8'd8, 8'd14, 8'd30, 8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd48: w = 1'b1;
      default: w = 1'b0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/sbpe_queue.sv @@
// Short job queue between the front and the back of the packet engine.
// Depends on sbpe_pkg for the job type.
module sbpe_queue #(
  parameter int unsigned Depth = sbpe_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbpe_pkg::job_t  push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sbpe_pkg::job_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sbpe_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/sbpe_front.sv @@
// Front of the packet engine: takes requests, tracks and checks reply bytes,
// and queues packet and completion jobs. Depends on sbpe_pkg.
module sbpe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      opcode_i,
  input  logic [7:0]      servo_id_i,
  input  logic [7:0]      reg_address_i,
  input  logic [15:0]     write_value_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            rx_last_i,
  input  logic [1:0]      return_level_i,
  output logic            push_o,
  output sbpe_pkg::job_t  push_job_o,
  input  logic            q_full_i
);

  localparam int unsigned NumFld = 5;

  logic        await_q, await_d;
  logic        for_read_q, for_read_d;
  logic [7:0]  exp_id_q, exp_id_d;
  logic        two_q, two_d;
  logic [8:0]  cnt_q, cnt_d;
  logic        hdr_q, hdr_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  fld_q [NumFld];
  logic [7:0]  fld_d [NumFld];
  logic [7:0]  fld_eff [NumFld];

  logic        is_read, wide, no_reply;
  logic [9:0]  n_bytes;
  sbpe_pkg::opcode_e op;
  sbpe_pkg::ret_level_e rl;
  sbpe_pkg::job_t job;

  assign in_stall_o = q_full_i;
  assign op         = sbpe_pkg::opcode_e'(opcode_i);
  assign rl         = sbpe_pkg::ret_level_e'(return_level_i);
  assign is_read    = (op == sbpe_pkg::OP_READ);
  assign wide       = sbpe_pkg::is_wide(reg_address_i);
  assign no_reply   = (servo_id_i == sbpe_pkg::BROADCAST_ID) || (rl == sbpe_pkg::RL_NONE) ||
                      ((rl == sbpe_pkg::RL_READS) && !is_read);
  assign n_bytes    = {1'b0, cnt_q} + 10'd1;

  // Reply fields as they stand once the current byte has been stored.
  always_comb begin
    for (int i = 0; i < NumFld; i++) begin
      fld_eff[i] = (cnt_q == 9'(i + 2)) ? rx_byte_i : fld_q[i];
    end
  end

  always_comb begin
    await_d    = await_q;
    for_read_d = for_read_q;
    exp_id_d   = exp_id_q;
    two_d      = two_q;
    cnt_d      = cnt_q;
    hdr_d      = hdr_q;
    sum_d      = sum_q;
    fld_d      = fld_q;
    push_o     = 1'b0;
    job        = '0;
    job.status = sbpe_pkg::ST_OK;
    if (in_valid_i && !q_full_i) begin
      case (op)
        sbpe_pkg::OP_WRITE, sbpe_pkg::OP_READ: begin
          push_o       = 1'b1;
          job.is_pkt   = 1'b1;
          job.is_read  = is_read;
          job.wide     = wide;
          job.need_cpl = no_reply;
          job.id       = servo_id_i;
          job.addr     = reg_address_i;
          job.val      = write_value_i;
          await_d      = !no_reply;
          for_read_d   = is_read;
          exp_id_d     = servo_id_i;
          two_d        = wide;
          cnt_d        = '0;
          hdr_d        = 1'b1;
          sum_d        = '0;
          for (int i = 0; i < NumFld; i++) begin
            fld_d[i] = '0;
          end
        end
        sbpe_pkg::OP_REPLY: begin
          if (await_q) begin
            if (cnt_q < 9'd2 && rx_byte_i != sbpe_pkg::HDR_BYTE) begin
              hdr_d = 1'b0;
            end
            fld_d = fld_eff;
            if (!rx_last_i) begin
              if (cnt_q >= 9'd2) begin
                sum_d = sum_q + rx_byte_i;
              end
              if (cnt_q != '1) begin
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              push_o  = 1'b1;
              await_d = 1'b0;
              if (n_bytes < 10'(sbpe_pkg::MIN_REPLY_LEN)) begin
                job.status = sbpe_pkg::ST_SHORT;
              end else if (!hdr_q) begin
                job.status = sbpe_pkg::ST_BAD_HDR;
              end else if (~sum_q != rx_byte_i) begin
                job.status = sbpe_pkg::ST_BAD_SUM;
              end else if ({2'b00, fld_eff[1]} + 10'(sbpe_pkg::LEN_OVERHEAD) != n_bytes) begin
                job.status = sbpe_pkg::ST_BAD_LEN;
              end else if (fld_eff[2] != 8'd0) begin
                job.status = sbpe_pkg::ST_DEV_ERR;
                job.err    = fld_eff[2];
              end else if (for_read_q && fld_eff[0] != exp_id_q) begin
                job.status = sbpe_pkg::ST_WRONG_ID;
              end else if (for_read_q) begin
                job.rval = {two_q ? fld_eff[4] : 8'd0, fld_eff[3]};
              end
            end
          end
        end
        sbpe_pkg::OP_EMPTY: begin
          if (await_q) begin
            push_o     = 1'b1;
            await_d    = 1'b0;
            job.status = sbpe_pkg::ST_NO_REPLY;
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  assign push_job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q    <= 1'b0;
      for_read_q <= 1'b0;
      exp_id_q   <= '0;
      two_q      <= 1'b0;
      cnt_q      <= '0;
      hdr_q      <= 1'b1;
      sum_q      <= '0;
      for (int i = 0; i < NumFld; i++) begin
        fld_q[i] <= '0;
      end
    end else begin
      await_q    <= await_d;
      for_read_q <= for_read_d;
      exp_id_q   <= exp_id_d;
      two_q      <= two_d;
      cnt_q      <= cnt_d;
      hdr_q      <= hdr_d;
      sum_q      <= sum_d;
      fld_q      <= fld_d;
    end
  end

endmodule

@@ rtl/sbpe_back.sv @@
// Back of the packet engine: frames queued commands into bytes, emits
// completions, and holds the result in an output register. Depends on sbpe_pkg.
module sbpe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  sbpe_pkg::job_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [7:0]      tx_byte_o,
  output logic            tx_last_o,
  output logic [2:0]      status_o,
  output logic [7:0]      device_error_bits_o,
  output logic [15:0]     read_value_o
);

  logic [3:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic        out_vld_q, out_vld_d;
  sbpe_pkg::kind_e   kind_q, kind_d;
  logic [7:0]  txb_q, txb_d;
  logic        txl_q, txl_d;
  sbpe_pkg::status_e st_q, st_d;
  logic [7:0]  err_q, err_d;
  logic [15:0] rval_q, rval_d;

  logic        advance, job_done, is_cpl_slot;
  logic [3:0]  last_idx;
  logic [7:0]  body_byte;

  // Reads and writes to one-byte registers are 8 bytes long, writes to
  // two-byte registers 9.
  assign last_idx    = (head_i.wide && !head_i.is_read) ? 4'd8 : 4'd7;
  assign is_cpl_slot = !head_i.is_pkt || (idx_q == last_idx + 4'd1);
  assign advance     = q_valid_i && (!out_vld_q || !out_stall_i);
  assign job_done    = !head_i.is_pkt || is_cpl_slot ||
                       ((idx_q == last_idx) && !head_i.need_cpl);
  assign pop_o       = advance && job_done;

  always_comb begin
    case (idx_q)
      4'd0, 4'd1: body_byte = sbpe_pkg::HDR_BYTE;
      4'd2:       body_byte = head_i.id;
      4'd3:       body_byte = (head_i.is_read || !head_i.wide) ? 8'd4 : 8'd5;
      4'd4:       body_byte = head_i.is_read ? sbpe_pkg::INS_READ : sbpe_pkg::INS_WRITE;
      4'd5:       body_byte = head_i.addr;
      4'd6:       body_byte = head_i.is_read ? (head_i.wide ? 8'd2 : 8'd1) : head_i.val[7:0];
      4'd7:       body_byte = head_i.val[15:8];
      default:    body_byte = 8'd0;
    endcase
  end

  always_comb begin
    idx_d     = idx_q;
    sum_d     = sum_q;
    out_vld_d = out_vld_q && out_stall_i;
    kind_d    = kind_q;
    txb_d     = txb_q;
    txl_d     = txl_q;
    st_d      = st_q;
    err_d     = err_q;
    rval_d    = rval_q;
    if (advance) begin
      out_vld_d = 1'b1;
      idx_d     = job_done ? 4'd0 : idx_q + 4'd1;
      if (is_cpl_slot) begin
        kind_d = sbpe_pkg::KIND_CPL;
        txb_d  = '0;
        txl_d  = 1'b0;
        st_d   = head_i.status;
        err_d  = head_i.err;
        rval_d = head_i.rval;
      end else begin
        kind_d = sbpe_pkg::KIND_TX;
        st_d   = sbpe_pkg::ST_OK;
        err_d  = '0;
        rval_d = '0;
        txl_d  = (idx_q == last_idx);
        txb_d  = (idx_q == last_idx) ? ~sum_q : body_byte;
        sum_d  = (idx_q < 4'd2) ? 8'd0 : sum_q + body_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    kind_q <= kind_d;
    txb_q  <= txb_d;
    txl_q  <= txl_d;
    st_q   <= st_d;
    err_q  <= err_d;
    rval_q <= rval_d;
  end

  assign out_valid_o         = out_vld_q;
  assign kind_o              = kind_q;
  assign tx_byte_o           = txb_q;
  assign tx_last_o           = txl_q;
  assign status_o            = st_q;
  assign device_error_bits_o = err_q;
  assign read_value_o        = rval_q;

endmodule

@@ rtl/servo_bus_packet_engine.sv @@
// Top level of the servo bus packet engine: front, job queue and back.
// Depends on sbpe_pkg, sbpe_front, sbpe_queue and sbpe_back.
//
// Usage. Requests enter on the input channel (in_valid_i / in_stall_o): a
// write or read command, one byte of a device reply, or the notice that a
// reply ended empty. Results leave on the output channel (out_valid_o /
// out_stall_i): each is either one transmit byte of a command packet or the
// completion of a transaction with its status and read data.
// A command yields 8 or 9 packet bytes, the last marked by tx_last_o, and,
// when no reply is awaited, a completion straight after. A reply yields a
// single completion on its final byte, or on the empty notice.
// The user writes the return level register on the cfg channel only while idle;
// the block itself has no check for it. Timing. The first result of a request
// passes the job queue, then the output register. Reply bytes are accepted one
// per cycle while the queue is not full. The back emits one result per cycle
// while out_stall_i is low, so a command yields 8 to 10 results; the four-entry
// job queue lets requests keep entering meanwhile, and the input stalls only
// while that queue is full. Stalls. While out_stall_i is high, the output
// register holds a shown result and the back waits; the front keeps running
// until the queue fills. Reset clears the queue, the reply tracking and the
// output valid flag, and sets the return level to 1 (replies to reads only).
module servo_bus_packet_engine #(
  parameter int unsigned QueueDepth = sbpe_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  servo_id_i,
  input  logic [7:0]  reg_address_i,
  input  logic [15:0] write_value_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [2:0]  status_o,
  output logic [7:0]  device_error_bits_o,
  output logic [15:0] read_value_o
);

  // The return level register accepts a request in every cycle.
  logic [1:0] ret_level_q;

  logic           push, q_full, q_valid, pop;
  sbpe_pkg::job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_level_q <= sbpe_pkg::RL_READS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ret_level_q <= cfg_data_i;
    end
  end

  // Front: classifies each request, checks reply bytes as they arrive.
  sbpe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .servo_id_i     (servo_id_i),
    .reg_address_i  (reg_address_i),
    .write_value_i  (write_value_i),
    .rx_byte_i      (rx_byte_i),
    .rx_last_i      (rx_last_i),
    .return_level_i (ret_level_q),
    .push_o         (push),
    .push_job_o     (push_job),
    .q_full_i       (q_full)
  );

  // Queue: decouples the request side from the result side.
  sbpe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // Back: serialises packets and completions into the output register.
  sbpe_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .head_i              (head_job),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .tx_byte_o           (tx_byte_o),
    .tx_last_o           (tx_last_o),
    .status_o            (status_o),
    .device_error_bits_o (device_error_bits_o),
    .read_value_o        (read_value_o)
  );

endmodule

@@ rtl/sbpe_checker.sv @@
// Port-level checks of the servo bus packet engine, bound to its top level.
// Depends on sbpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  tx_byte_o,
  input logic        tx_last_o,
  input logic [2:0]  status_o,
  input logic [7:0]  device_error_bits_o,
  input logic [15:0] read_value_o
);

  `SBPE_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(kind_o) &&
      $stable(tx_byte_o) && $stable(status_o) && $stable(read_value_o)),
    "stalled result changed")

  `SBPE_ASSERT(a_cpl_no_byte, clk_i, rst_ni,
    (out_valid_o && kind_o == sbpe_pkg::KIND_CPL) |-> (tx_byte_o == 8'd0 && !tx_last_o),
    "completion carries a packet byte")

  `SBPE_ASSERT(a_tx_no_status, clk_i, rst_ni,
    (out_valid_o && kind_o == sbpe_pkg::KIND_TX) |-> (status_o == sbpe_pkg::ST_OK &&
      device_error_bits_o == 8'd0 && read_value_o == 16'd0),
    "transmit byte carries completion data")

  `SBPE_ASSERT(a_err_only_dev, clk_i, rst_ni,
    (out_valid_o && status_o != sbpe_pkg::ST_DEV_ERR) |-> (device_error_bits_o == 8'd0),
    "error bits without device error")

  `SBPE_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule

bind servo_bus_packet_engine sbpe_checker u_sbpe_checker (.*);
